### rtl/dtbc_pkg.sv
package dtbc_pkg;

  localparam int DefaultRounds = 16;
  localparam int MaxRounds = 16;
  localparam int BlockWidth = 64;
  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] RegKeyOne = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegKeyTwo = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegKeyThree = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegTripleEnable = 2'd3;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] ip_fn(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] fp_fn(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1_fn(input logic [63:0] k);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = k[64 - int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] pc2_fn(input logic [55:0] cd);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = cd[56 - int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    if (s == 2'd2) r = {v[25:0], v[27:26]};
    else r = {v[26:0], v[27]};
    return r;
  endfunction

  // Subkey n for a key, built from the constant rotation schedule of rounds 0 to n
  function automatic logic [47:0] subkey_fn(input logic [63:0] key, input int n);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    cd = pc1_fn(key);
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      if (i <= n) begin
        c = rot28(c, TabRot[i]);
        d = rot28(d, TabRot[i]);
      end
    end
    return pc2_fn({c, d});
  endfunction

  function automatic logic [31:0] feistel_fn(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TabP[i])];
    return p;
  endfunction

endpackage

### rtl/des_tdes_block_cipher_unit.sv
// Pipeline: an accepted item passes one round per stage through three DES passes, then
// one output stage holds its result.
// Throughput: one item per cycle; the whole pipe holds while the output is stalled.
// Reset: rst clears all valid bits and the config registers to zero; keys are single-key zero.
module des_tdes_block_cipher_unit
  import dtbc_pkg::*;
#(
  parameter int ROUNDS = DefaultRounds
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [63:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [63:0]              data_in,
  input  logic                     mode,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [63:0]              data_out
);

  localparam int NumRounds = (ROUNDS > MaxRounds) ? MaxRounds : ROUNDS;
  localparam int NumStages = 3 * NumRounds;

  logic [63:0] key_one;
  logic [63:0] key_two;
  logic [63:0] key_three;
  logic        triple_enable;
  logic        advance;

  logic        sv_valid [NumStages+1];
  logic [31:0] sv_left  [NumStages+1];
  logic [31:0] sv_right [NumStages+1];
  logic        sv_dec   [NumStages+1];
  logic [63:0] pass_in  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_one       <= '0;
      key_two       <= '0;
      key_three     <= '0;
      triple_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegKeyOne:       key_one       <= cfg_data;
        RegKeyTwo:       key_two       <= cfg_data;
        RegKeyThree:     key_three     <= cfg_data;
        RegTripleEnable: triple_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Pick the pass key by item mode (ka on encrypt, kb on decrypt) and invert the
  // item direction where flip is set. Single mode runs an inverse pair under key one
  // in passes 0 and 1, which cancel, then the real pass under key one.
  logic [63:0] ka [3];
  logic [63:0] kb [3];
  logic        flip [3];

  always_comb begin
    if (triple_enable) begin
      ka[0] = key_one;   kb[0] = key_three; flip[0] = 1'b0;
      ka[1] = key_two;   kb[1] = key_two;   flip[1] = 1'b1;
      ka[2] = key_three; kb[2] = key_one;   flip[2] = 1'b0;
    end else begin
      ka[0] = key_one;   kb[0] = key_one;   flip[0] = 1'b1;
      ka[1] = key_one;   kb[1] = key_one;   flip[1] = 1'b0;
      ka[2] = key_one;   kb[2] = key_one;   flip[2] = 1'b0;
    end
  end

  logic [63:0] ip_in;
  assign ip_in = ip_fn(data_in);
  assign sv_valid[0] = in_valid;
  assign sv_left[0]  = ip_in[63:32];
  assign sv_right[0] = ip_in[31:0];
  assign sv_dec[0]   = mode;

  genvar gp, gr;
  generate
    for (gp = 0; gp < 3; gp++) begin : g_pass
      logic        pv_valid [NumRounds+1];
      logic [31:0] pv_left  [NumRounds+1];
      logic [31:0] pv_right [NumRounds+1];
      logic        pv_dec   [NumRounds+1];
      logic        mode_reg [NumRounds+1];
      logic [63:0] fixed;

      if (gp == 0) begin : g_first
        assign pv_left[0]  = sv_left[0];
        assign pv_right[0] = sv_right[0];
      end else begin : g_next
        // inter-pass: swap, FP, then IP; FP and IP cancel, leaving the swap
        assign fixed = {sv_right[gp*NumRounds], sv_left[gp*NumRounds]};
        assign pv_left[0]  = fixed[63:32];
        assign pv_right[0] = fixed[31:0];
      end
      if (gp == 0) begin : g_unused
        assign fixed = '0;
      end
      assign pv_valid[0] = sv_valid[gp*NumRounds];
      assign mode_reg[0] = sv_dec[gp*NumRounds];
      // effective direction of this pass: item mode xor flip
      assign pv_dec[0] = mode_reg[0] ^ flip[gp];

      for (gr = 0; gr < NumRounds; gr++) begin : g_round
        logic dec_out;
        dtbc_round u_round (
          .clk      (clk),
          .rst      (rst),
          .advance  (advance),
          .valid_in (pv_valid[gr]),
          .left_in  (pv_left[gr]),
          .right_in (pv_right[gr]),
          .dec_in   (pv_dec[gr]),
          .key_enc  (subkey_fn(mode_reg[gr] ? kb[gp] : ka[gp], gr)),
          .key_dec  (subkey_fn(mode_reg[gr] ? kb[gp] : ka[gp], NumRounds - 1 - gr)),
          .valid    (pv_valid[gr+1]),
          .left     (pv_left[gr+1]),
          .right    (pv_right[gr+1]),
          .dec      (dec_out)
        );
        always_ff @(posedge clk) begin
          if (advance) mode_reg[gr+1] <= mode_reg[gr];
        end
        if (gr + 1 < NumRounds) begin : g_dec
          assign pv_dec[gr+1] = dec_out;
        end else begin : g_dec_last
          assign pv_dec[gr+1] = dec_out;
        end
      end

      assign sv_valid[(gp+1)*NumRounds] = pv_valid[NumRounds];
      assign sv_left[(gp+1)*NumRounds]  = pv_left[NumRounds];
      assign sv_right[(gp+1)*NumRounds] = pv_right[NumRounds];
      assign sv_dec[(gp+1)*NumRounds]   = mode_reg[NumRounds] ^ (pv_dec[NumRounds] & 1'b0);
      assign pass_in[gp] = fixed;
    end
    for (gp = 0; gp < 3; gp++) begin : g_fill
      for (gr = 1; gr < NumRounds; gr++) begin : g_mid
        assign sv_valid[gp*NumRounds+gr] = g_pass[gp].pv_valid[gr];
        assign sv_left[gp*NumRounds+gr]  = g_pass[gp].pv_left[gr];
        assign sv_right[gp*NumRounds+gr] = g_pass[gp].pv_right[gr];
        assign sv_dec[gp*NumRounds+gr]   = g_pass[gp].mode_reg[gr] ^ (|pass_in[gp] & 1'b0);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sv_valid[NumStages];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_out <= fp_fn({sv_right[NumStages], sv_left[NumStages]});
    end
  end

endmodule

### rtl/dtbc_round.sv
module dtbc_round
  import dtbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        valid_in,
  input  logic [31:0] left_in,
  input  logic [31:0] right_in,
  input  logic        dec_in,
  input  logic [47:0] key_enc,
  input  logic [47:0] key_dec,
  output logic        valid,
  output logic [31:0] left,
  output logic [31:0] right,
  output logic        dec
);

  logic [47:0] key_sel;

  assign key_sel = dec_in ? key_dec : key_enc;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left  <= right_in;
      right <= left_in ^ feistel_fn(right_in, key_sel);
      dec   <= dec_in;
    end
  end

endmodule

### rtl/dtbc_checker.sv
module dtbc_checker
  import dtbc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] data_out
);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(data_out)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid right after reset");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

endmodule

bind des_tdes_block_cipher_unit dtbc_checker u_dtbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out)
);
